### src/lmps_pkg.sv
// Shared types and constants of the low-power mode selector.
`default_nettype none

package lmps_pkg;

   // Event codes on the request channel
   localparam logic [2:0] EV_UNLOCK   = 3'd0;
   localparam logic [2:0] EV_LOCK     = 3'd1;
   localparam logic [2:0] EV_ENTER    = 3'd2;
   localparam logic [2:0] EV_WAKE     = 3'd3;
   localparam logic [2:0] EV_STANDBY  = 3'd4;
   localparam logic [2:0] EV_SHUTDOWN = 3'd5;

   // Selectable sleep depths
   localparam logic [1:0] PM_RUN     = 2'd0;
   localparam logic [1:0] PM_SLEEP   = 2'd1;
   localparam logic [1:0] PM_LPSLEEP = 2'd2;
   localparam logic [1:0] PM_STOP    = 2'd3;

   // Wake timer sources
   localparam logic [1:0] WS_NONE  = 2'd0;
   localparam logic [1:0] WS_LPTIM = 2'd1;
   localparam logic [1:0] WS_RTC   = 2'd2;

   // Configuration registers
   localparam int         CSR_AW          = 3;
   localparam logic       REG_SHORT       = 1'b0;
   localparam logic       REG_RTC_THR     = 1'b1;
   localparam logic [15:0] SHORT_RESET    = 16'd2;
   localparam logic [31:0] RTC_THR_RESET  = 32'd2000;

   // Arithmetic
   localparam int               TOTAL_W   = 48;
   localparam int               IDLE_W    = 14;
   localparam logic [IDLE_W-1:0] IDLE_FULL = 14'd10000;
   localparam logic [9:0]       MS_PER_S  = 10'd1000;
   // ceil(2^38 / 1000): exact for every 32-bit dividend
   localparam logic [28:0]      MS_RECIP  = 29'd274877907;
   localparam int               MS_SHIFT  = 38;
   localparam int               DIV_W     = 64;
   localparam int               DEN_W     = 48;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_LOAD,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic div_start;
      logic res_load;
   } dp_cmd_type;

   typedef struct packed {
      logic need_div;
      logic div_done;
      logic out_free;
   } dp_sts_type;

endpackage

`default_nettype wire

### src/lmps_if.sv
// Request and response channel interfaces of the low-power mode selector.
`default_nettype none

interface lmps_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  mode;
   logic [2:0]  power_mode;
   logic [31:0] next_due_ms;
   logic [31:0] lptim_elapsed_ms;
   logic [31:0] rtc_time_ms;
   logic [47:0] since_boot_ms;
   logic [2:0]  wake_pin;
   logic        wake_edge;

   modport source (
      output valid, mode, power_mode, next_due_ms, lptim_elapsed_ms,
             rtc_time_ms, since_boot_ms, wake_pin, wake_edge,
      input  ready
   );
   modport sink (
      input  valid, mode, power_mode, next_due_ms, lptim_elapsed_ms,
             rtc_time_ms, since_boot_ms, wake_pin, wake_edge,
      output ready
   );
endinterface

interface lmps_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  chosen_mode;
   logic [1:0]  wake_source;
   logic [31:0] wake_count;
   logic [31:0] tick_ms;
   logic [13:0] idle_percent_x100;
   logic        granted;
   logic [2:0]  out_pin;
   logic        out_edge;

   modport source (
      output valid, chosen_mode, wake_source, wake_count, tick_ms,
             idle_percent_x100, granted, out_pin, out_edge,
      input  ready
   );
   modport sink (
      input  valid, chosen_mode, wake_source, wake_count, tick_ms,
             idle_percent_x100, granted, out_pin, out_edge,
      output ready
   );
endinterface

`default_nettype wire

### src/lmps_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none

module lmps_div
   import lmps_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic             done,
   output logic [DIV_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIV_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             fits;

   assign trial = {rem_ff, quo_ff[DIV_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '1;
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

### src/lmps_dp.sv
// Datapath: lock counters, sleep timing state, divider and result register.
`default_nettype none

module lmps_dp
   import lmps_pkg::*;
#(
   parameter int MODE_COUNT = 6,
   parameter int LOCK_BITS  = 8
)
(
   input  logic        clock,
   input  logic        reset,
   input  dp_cmd_type  cmd,
   output dp_sts_type  sts,
   input  logic [15:0] short_limit_ms,
   input  logic [31:0] rtc_threshold_ms,
   input  logic [2:0]  mode,
   input  logic [2:0]  power_mode,
   input  logic [31:0] next_due_ms,
   input  logic [31:0] lptim_elapsed_ms,
   input  logic [31:0] rtc_time_ms,
   input  logic [47:0] since_boot_ms,
   input  logic [2:0]  wake_pin,
   input  logic        wake_edge,
   input  logic        rsp_ready,
   output logic        rsp_valid,
   output logic [1:0]  chosen_mode,
   output logic [1:0]  wake_source,
   output logic [31:0] wake_count,
   output logic [31:0] tick_ms,
   output logic [13:0] idle_percent_x100,
   output logic        granted,
   output logic [2:0]  out_pin,
   output logic        out_edge
);

   localparam int IDX_W = $clog2(MODE_COUNT);

   // Captured request
   logic [2:0]         ev_ff;
   logic [2:0]         pm_ff;
   logic [31:0]        deadline_ff;
   logic [31:0]        lpt_ff;
   logic [31:0]        rtc_ff;
   logic [TOTAL_W-1:0] uptime_ff;
   logic [2:0]         pin_ff;
   logic               edge_ff;

   // Persistent state
   logic [LOCK_BITS-1:0] lock_ff [MODE_COUNT];
   logic [LOCK_BITS-1:0] lock_in [MODE_COUNT];
   logic [1:0]           timer_ff, timer_in;
   logic [31:0]          start_ff, start_in;
   logic [TOTAL_W-1:0]   total_ff, total_in;

   // Staged result
   logic [1:0]  st_chosen_ff, st_chosen_in;
   logic [1:0]  st_src_ff, st_src_in;
   logic [31:0] st_count_ff, st_count_in;
   logic [31:0] st_tick_ff, st_tick_in;
   logic        st_granted_ff, st_granted_in;
   logic [2:0]  st_pin_ff, st_pin_in;
   logic        st_edge_ff, st_edge_in;
   logic        st_q_idle_ff, st_q_idle_in;

   // Result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_chosen_ff;
   logic [1:0]        rsp_src_ff;
   logic [31:0]       rsp_count_ff;
   logic [31:0]       rsp_tick_ff;
   logic [IDLE_W-1:0] rsp_idle_ff;
   logic              rsp_granted_ff;
   logic [2:0]        rsp_pin_ff;
   logic              rsp_edge_ff;

   logic [2:0]           sel_mode;
   logic                 in_range;
   logic [LOCK_BITS-1:0] sel_lock;
   logic [1:0]           chosen;
   logic                 use_rtc;
   logic [60:0]          count_prod;
   logic [31:0]          elapsed;
   logic [TOTAL_W:0]     total_sum;
   logic [61:0]          idle_prod;
   logic [DIV_W-1:0]     div_dividend;
   logic [DEN_W-1:0]     div_divisor;
   logic                 div_done;
   logic [DIV_W-1:0]     quotient;
   logic [IDLE_W-1:0]    idle_val;

   // Standby and shutdown look up their own counter, lock events the named one
   assign sel_mode = (ev_ff == EV_STANDBY || ev_ff == EV_SHUTDOWN) ? ev_ff : pm_ff;
   assign in_range = {1'b0, sel_mode} < 4'(MODE_COUNT);
   assign sel_lock = in_range ? lock_ff[sel_mode[IDX_W-1:0]] : '0;

   // Deepest mode whose lock and shallower sleep locks are clear; a zero deadline gives run, a short one sleep at most
   always_comb begin
      if (deadline_ff == '0 || lock_ff[1] != '0) begin
         chosen = PM_RUN;
      end else if (deadline_ff <= {16'b0, short_limit_ms} || lock_ff[2] != '0) begin
         chosen = PM_SLEEP;
      end else if (lock_ff[3] != '0) begin
         chosen = PM_LPSLEEP;
      end else begin
         chosen = PM_STOP;
      end
   end

   assign use_rtc = deadline_ff >= rtc_threshold_ms;

   // Whole seconds for the RTC by reciprocal multiplication
   assign count_prod = deadline_ff * MS_RECIP;

   always_comb begin
      case (timer_ff)
         WS_LPTIM: elapsed = lpt_ff;
         WS_RTC:   elapsed = rtc_ff - start_ff;
         default:  elapsed = '0;
      endcase
   end

   assign total_sum = {1'b0, total_ff} + (TOTAL_W+1)'(elapsed);

   always_comb begin
      for (int i = 0; i < MODE_COUNT; i++) begin
         lock_in[i] = lock_ff[i];
         if (cmd.exec && in_range && sel_mode[IDX_W-1:0] == IDX_W'(i)) begin
            if (ev_ff == EV_UNLOCK && lock_ff[i] != '0) begin
               lock_in[i] = lock_ff[i] - 1'b1;
            end else if (ev_ff == EV_LOCK && lock_ff[i] != '1) begin
               lock_in[i] = lock_ff[i] + 1'b1;
            end
         end
      end
   end

   always_comb begin
      timer_in      = timer_ff;
      start_in      = start_ff;
      total_in      = total_ff;
      st_chosen_in  = st_chosen_ff;
      st_src_in     = st_src_ff;
      st_count_in   = st_count_ff;
      st_tick_in    = st_tick_ff;
      st_granted_in = st_granted_ff;
      st_pin_in     = st_pin_ff;
      st_edge_in    = st_edge_ff;
      st_q_idle_in  = st_q_idle_ff;
      if (cmd.exec) begin
         st_chosen_in  = PM_RUN;
         st_src_in     = WS_NONE;
         st_count_in   = '0;
         st_tick_in    = '0;
         st_granted_in = 1'b0;
         st_pin_in     = '0;
         st_edge_in    = 1'b0;
         st_q_idle_in  = 1'b0;
         case (ev_ff) inside
            EV_ENTER: begin
               st_chosen_in = chosen;
               if (chosen != PM_RUN) begin
                  if (use_rtc) begin
                     timer_in    = WS_RTC;
                     start_in    = rtc_ff;
                     st_src_in   = WS_RTC;
                     st_count_in = 32'(count_prod[60:MS_SHIFT]);
                  end else begin
                     timer_in    = WS_LPTIM;
                     st_src_in   = WS_LPTIM;
                     st_count_in = deadline_ff;
                  end
               end
            end
            EV_WAKE: begin
               st_tick_in   = elapsed;
               st_q_idle_in = uptime_ff != '0;
               if (elapsed != '0) begin
                  total_in = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
               end
            end
            EV_STANDBY, EV_SHUTDOWN: begin
               if (sel_lock == '0) begin
                  st_granted_in = 1'b1;
                  st_pin_in     = pin_ff;
                  st_edge_in    = edge_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign sts.need_div = ev_ff == EV_WAKE && uptime_ff != '0;

   // Idle share uses the total already updated by this wake
   assign idle_prod    = total_ff * IDLE_FULL;
   assign div_dividend = DIV_W'(idle_prod);
   assign div_divisor  = uptime_ff;

   lmps_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (quotient)
   );

   assign sts.div_done = div_done;
   assign idle_val     = (quotient > DIV_W'(IDLE_FULL)) ? IDLE_FULL : quotient[IDLE_W-1:0];

   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.res_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MODE_COUNT; i++) begin
            lock_ff[i] <= '0;
         end
         timer_ff     <= WS_NONE;
         start_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         for (int i = 0; i < MODE_COUNT; i++) begin
            lock_ff[i] <= lock_in[i];
         end
         timer_ff     <= timer_in;
         start_ff     <= start_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         ev_ff       <= mode;
         pm_ff       <= power_mode;
         deadline_ff <= next_due_ms;
         lpt_ff      <= lptim_elapsed_ms;
         rtc_ff      <= rtc_time_ms;
         uptime_ff   <= since_boot_ms;
         pin_ff      <= wake_pin;
         edge_ff     <= wake_edge;
      end
      st_chosen_ff  <= st_chosen_in;
      st_src_ff     <= st_src_in;
      st_count_ff   <= st_count_in;
      st_tick_ff    <= st_tick_in;
      st_granted_ff <= st_granted_in;
      st_pin_ff     <= st_pin_in;
      st_edge_ff    <= st_edge_in;
      st_q_idle_ff  <= st_q_idle_in;
      if (cmd.res_load) begin
         rsp_chosen_ff  <= st_chosen_ff;
         rsp_src_ff     <= st_src_ff;
         rsp_count_ff   <= st_count_ff;
         rsp_tick_ff    <= st_tick_ff;
         rsp_idle_ff    <= st_q_idle_ff ? idle_val : '0;
         rsp_granted_ff <= st_granted_ff;
         rsp_pin_ff     <= st_pin_ff;
         rsp_edge_ff    <= st_edge_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign chosen_mode       = rsp_chosen_ff;
   assign wake_source       = rsp_src_ff;
   assign wake_count        = rsp_count_ff;
   assign tick_ms           = rsp_tick_ff;
   assign idle_percent_x100 = rsp_idle_ff;
   assign granted           = rsp_granted_ff;
   assign out_pin           = rsp_pin_ff;
   assign out_edge          = rsp_edge_ff;

endmodule

`default_nettype wire

### src/lmps_ctrl.sv
// Controller: sequences capture, execute, divide and result load per event.
`default_nettype none

module lmps_ctrl
   import lmps_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = sts.need_div ? ST_LOAD : ST_DONE;
         end
         ST_LOAD: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (sts.div_done) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready     = 1'b0;
      cmd           = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
         end
         ST_LOAD: begin
            cmd.div_start = 1'b1;
         end
         ST_DIV: begin
         end
         ST_DONE: begin
            // hold the result until the output register drains
            cmd.res_load = sts.out_free;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

### src/low_power_mode_selector.sv
// Low-power mode selector top level: register port, controller and datapath.
// Every event except a wake with a nonzero uptime runs execute and then result load;
// such a wake runs the 64-step bit-serial divider for the idle share in between.
// One event at a time; the next beat is taken the cycle after the result is loaded,
// and a stall on the result channel delays that load.
// Reset (synchronous): lock counters, armed timer, sleep start, total and result valid cleared, registers to defaults.
`default_nettype none

module low_power_mode_selector
   import lmps_pkg::*;
#(
   parameter int MODE_COUNT = 6,
   parameter int LOCK_BITS  = 8
)
(
   input  logic              clock,
   input  logic              reset,
   lmps_req_if.sink          req_ch,
   lmps_rsp_if.source        rsp_ch,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   logic [15:0] short_ff, short_in;
   logic [31:0] rtc_thr_ff, rtc_thr_in;
   logic        csr_wr;
   dp_cmd_type  cmd;
   dp_sts_type  sts;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_comb begin
      short_in   = short_ff;
      rtc_thr_in = rtc_thr_ff;
      if (csr_wr) begin
         unique case (paddr[2])
            REG_SHORT:   short_in   = pwdata[15:0];
            REG_RTC_THR: rtc_thr_in = pwdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_SHORT:   prdata = {16'b0, short_ff};
         REG_RTC_THR: prdata = rtc_thr_ff;
         default:     prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         short_ff   <= SHORT_RESET;
         rtc_thr_ff <= RTC_THR_RESET;
      end else begin
         short_ff   <= short_in;
         rtc_thr_ff <= rtc_thr_in;
      end
   end

   lmps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   lmps_dp #(
      .MODE_COUNT (MODE_COUNT),
      .LOCK_BITS  (LOCK_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .short_limit_ms    (short_ff),
      .rtc_threshold_ms  (rtc_thr_ff),
      .mode              (req_ch.mode),
      .power_mode        (req_ch.power_mode),
      .next_due_ms       (req_ch.next_due_ms),
      .lptim_elapsed_ms  (req_ch.lptim_elapsed_ms),
      .rtc_time_ms       (req_ch.rtc_time_ms),
      .since_boot_ms     (req_ch.since_boot_ms),
      .wake_pin          (req_ch.wake_pin),
      .wake_edge         (req_ch.wake_edge),
      .rsp_ready         (rsp_ch.ready),
      .rsp_valid         (rsp_ch.valid),
      .chosen_mode       (rsp_ch.chosen_mode),
      .wake_source       (rsp_ch.wake_source),
      .wake_count        (rsp_ch.wake_count),
      .tick_ms           (rsp_ch.tick_ms),
      .idle_percent_x100 (rsp_ch.idle_percent_x100),
      .granted           (rsp_ch.granted),
      .out_pin           (rsp_ch.out_pin),
      .out_edge          (rsp_ch.out_edge)
   );

endmodule

`default_nettype wire
